// ===== design/product_except_self_unit_assert.svh =====
// assertion macros used by the controller, pes_ctrl
`ifndef PRODUCT_EXCEPT_SELF_UNIT_ASSERT_SVH
`define PRODUCT_EXCEPT_SELF_UNIT_ASSERT_SVH

// same-cycle implication
`define PES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pes_pkg.sv =====
package pes_pkg;

    localparam int DEF_MAX_ELEMENTS = 64;
    localparam int DEF_ELEMENT_BITS = 8;
    localparam int PRODUCT_BITS     = 64;
    localparam int DIGIT_BITS       = 16;

    typedef enum logic [1:0] {
        MS_LOAD,
        MS_BACK,
        MS_FWD
    } t_mul_src;

    typedef struct packed {
        logic     load_wr;
        logic     suffix_wr;
        logic     mul_start;
        t_mul_src mul_src;
        logic     run_set;
        logic     run_one;
        logic     acc_set;
        logic     acc_one;
        logic     out_load;
        logic     out_last;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic mul_done;
        logic out_free;
    } t_sts;

endpackage

// ===== design/pes_mul.sv =====
module pes_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [pes_pkg::PRODUCT_BITS-1:0]  i_a,
    input  logic [pes_pkg::PRODUCT_BITS-1:0]  i_b,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [pes_pkg::PRODUCT_BITS-1:0]  o_product
);

    localparam int PW = pes_pkg::PRODUCT_BITS;
    localparam int DW = pes_pkg::DIGIT_BITS;

    logic          r_busy;
    logic          r_done;
    logic [PW-1:0] r_a;
    logic [PW-1:0] r_b;
    logic [PW-1:0] r_acc;
    logic [PW+DW-1:0] w_pp;
    logic          w_final;

    // one 64x16 partial product per cycle
    assign w_pp    = r_a * r_b[DW-1:0];
    assign w_final = (r_b[PW-1:DW] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_final) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_pp[PW-1:0];
            r_a   <= r_a << DW;
            r_b   <= r_b >> DW;
        end
    end

    assign o_busy    = r_busy;
    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ===== design/pes_dp.sv =====
module pes_dp #(
    parameter int MAX_ELEMENTS = pes_pkg::DEF_MAX_ELEMENTS,
    parameter int ELEMENT_BITS = pes_pkg::DEF_ELEMENT_BITS,
    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pes_pkg::t_cmd                    i_cmd,
    input  logic [IW-1:0]                    i_addr,
    input  logic [ELEMENT_BITS-1:0]          i_s_data,
    input  logic                             i_m_ready,
    output pes_pkg::t_sts                    o_sts,
    output logic                             o_m_valid,
    output logic [pes_pkg::PRODUCT_BITS-1:0] o_m_data,
    output logic                             o_m_last
);

    localparam int PW = pes_pkg::PRODUCT_BITS;

    logic [ELEMENT_BITS-1:0] r_elem_mem   [MAX_ELEMENTS];
    logic [PW-1:0]           r_prefix_mem [MAX_ELEMENTS];
    logic [PW-1:0]           r_suffix_mem [MAX_ELEMENTS];
    logic [ELEMENT_BITS-1:0] r_elem_rd;
    logic [PW-1:0]           r_prefix_rd;
    logic [PW-1:0]           r_suffix_rd;

    logic [PW-1:0] r_run;
    logic [PW-1:0] r_acc;
    logic          r_out_valid;
    logic [PW-1:0] r_out_data;
    logic          r_out_last;

    logic [PW-1:0] w_mul_a;
    logic [PW-1:0] w_mul_b;
    logic          w_mul_busy;
    logic          w_mul_done;
    logic [PW-1:0] w_mul_product;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_elem_mem[i_addr]   <= i_s_data;
            r_prefix_mem[i_addr] <= r_run;
        end
        if (i_cmd.suffix_wr) begin
            r_suffix_mem[i_addr] <= r_acc;
        end
        r_elem_rd   <= r_elem_mem[i_addr];
        r_prefix_rd <= r_prefix_mem[i_addr];
        r_suffix_rd <= r_suffix_mem[i_addr];
    end

    always_comb begin
        unique case (i_cmd.mul_src)
            pes_pkg::MS_LOAD: begin
                w_mul_a = r_run;
                w_mul_b = PW'(i_s_data);
            end
            pes_pkg::MS_BACK: begin
                w_mul_a = r_acc;
                w_mul_b = PW'(r_elem_rd);
            end
            pes_pkg::MS_FWD: begin
                w_mul_a = r_prefix_rd;
                w_mul_b = r_suffix_rd;
            end
            default: begin
                w_mul_a = r_run;
                w_mul_b = '0;
            end
        endcase
    end

    pes_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_busy    (w_mul_busy),
        .o_done    (w_mul_done),
        .o_product (w_mul_product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= PW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.run_one) begin
                r_run <= PW'(1);
            end else if (i_cmd.run_set) begin
                r_run <= w_mul_product;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_one) begin
            r_acc <= PW'(1);
        end else if (i_cmd.acc_set) begin
            r_acc <= w_mul_product;
        end
        if (i_cmd.out_load) begin
            r_out_data <= w_mul_product;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_sts.mul_busy = w_mul_busy;
    assign o_sts.mul_done = w_mul_done;
    assign o_sts.out_free = !r_out_valid || i_m_ready;

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_last  = r_out_last;

endmodule

// ===== design/pes_ctrl.sv =====
`include "product_except_self_unit_assert.svh"

module pes_ctrl #(
    parameter int MAX_ELEMENTS = pes_pkg::DEF_MAX_ELEMENTS,
    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_s_last,
    output logic          o_s_ready,
    input  pes_pkg::t_sts i_sts,
    output pes_pkg::t_cmd o_cmd,
    output logic [IW-1:0] o_addr
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [3:0] {
        S_LOAD,
        S_LMUL,
        S_BRD,
        S_BSTART,
        S_BMUL,
        S_FRD,
        S_FSTART,
        S_FMUL,
        S_FOUT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_k, n_k;
    logic [IW-1:0] r_kl, n_kl;
    logic          r_mark, n_mark;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_k       = r_k;
        n_kl      = r_kl;
        n_mark    = r_mark;
        o_cmd     = '0;
        o_addr    = r_k;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_s_ready = 1'b1;
                o_addr    = r_cnt[IW-1:0];
                if (i_s_valid) begin
                    o_cmd.load_wr   = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = pes_pkg::MS_LOAD;
                    n_mark  = i_s_last || (r_cnt == CW'(MAX_ELEMENTS - 1));
                    n_state = S_LMUL;
                end
            end
            S_LMUL: begin
                if (i_sts.mul_done) begin
                    o_cmd.run_set = 1'b1;
                    if (r_mark) begin
                        o_cmd.acc_one = 1'b1;
                        n_k     = r_cnt[IW-1:0];
                        n_kl    = r_cnt[IW-1:0];
                        n_state = S_BRD;
                    end else begin
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_LOAD;
                    end
                end
            end
            S_BRD: begin
                o_cmd.suffix_wr = 1'b1;
                n_state = S_BSTART;
            end
            S_BSTART: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_src   = pes_pkg::MS_BACK;
                n_state = S_BMUL;
            end
            S_BMUL: begin
                if (i_sts.mul_done) begin
                    o_cmd.acc_set = 1'b1;
                    if (r_k == '0) begin
                        n_state = S_FRD;
                    end else begin
                        n_k     = r_k - IW'(1);
                        n_state = S_BRD;
                    end
                end
            end
            S_FRD: begin
                n_state = S_FSTART;
            end
            S_FSTART: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_src   = pes_pkg::MS_FWD;
                n_state = S_FMUL;
            end
            S_FMUL: begin
                if (i_sts.mul_done) begin
                    n_state = S_FOUT;
                end
            end
            S_FOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_k == r_kl);
                    if (r_k == r_kl) begin
                        o_cmd.run_one = 1'b1;
                        n_cnt   = '0;
                        n_k     = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + IW'(1);
                        n_state = S_FRD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_k     <= '0;
            r_kl    <= '0;
            r_mark  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_kl    <= n_kl;
            r_mark  <= n_mark;
        end
    end

    `PES_ASSERT_NOW(a_cnt_in_range, i_clk, i_rst_n, o_s_ready, int'(r_cnt) < MAX_ELEMENTS, "load index past store depth")
    `PES_ASSERT_NOW(a_out_free, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free, "output register overwritten")
    `PES_ASSERT_NOW(a_mul_idle, i_clk, i_rst_n, o_cmd.mul_start, !i_sts.mul_busy, "multiplier started while busy")
    `PES_ASSERT_NEXT(a_set_restart, i_clk, i_rst_n, o_cmd.out_load && o_cmd.out_last, (r_cnt == '0) && o_s_ready, "set did not restart")

endmodule

// ===== design/product_except_self_unit.sv =====
// product of all other elements of a set, without division
// input stream: one element per word, tlast marks the final element of the set;
// a set of MAX_ELEMENTS elements ends by itself even without tlast
// output stream: one 64-bit result per element in index order, each the product
// of all other elements modulo 2^64, tlast on the final result; a single element gives 1
// all products go through one shared multiplier that takes 16 multiplier bits a cycle,
// so a multiply stops once the remaining multiplier bits are zero, data dependent
// loading: each element is stored and multiplied into the running prefix product before
// the next element is taken; after the last element a backward pass builds the suffix
// products from the last element down, then a forward pass gives one result per element
// (prefix times suffix, read from the stores and multiplied in up to 4 steps)
// the first result follows the backward pass and its own multiply, which runs longer
// once the suffix product of the first element needs all 64 bits
// tready is high only while loading; it rises again as soon as the final result
// of a set sits in the output register, before that word is taken
// a stalled receiver holds the output register and stops the forward pass
// reset (synchronous, active low) empties the output and starts a new empty set
module product_except_self_unit #(
    parameter int MAX_ELEMENTS = pes_pkg::DEF_MAX_ELEMENTS,
    parameter int ELEMENT_BITS = pes_pkg::DEF_ELEMENT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // element_value
    input  logic [((ELEMENT_BITS+7)/8)*8-1:0]   i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // product_of_others
    output logic [pes_pkg::PRODUCT_BITS-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);

    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    pes_pkg::t_cmd w_cmd;
    pes_pkg::t_sts w_sts;
    logic [IW-1:0] w_addr;

    pes_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_last  (i_s_axis_tlast),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_addr    (w_addr)
    );

    pes_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_addr    (w_addr),
        .i_s_data  (i_s_axis_tdata[ELEMENT_BITS-1:0]),
        .i_m_ready (i_m_axis_tready),
        .o_sts     (w_sts),
        .o_m_valid (o_m_axis_tvalid),
        .o_m_data  (o_m_axis_tdata),
        .o_m_last  (o_m_axis_tlast)
    );

endmodule

// ===== tb/product_except_self_unit_tb.sv =====
module product_except_self_unit_tb;

    localparam int PRODUCT_BITS = pes_pkg::PRODUCT_BITS;
    localparam int MAX_EL       = pes_pkg::DEF_MAX_ELEMENTS;
    localparam int ELEM_BITS    = pes_pkg::DEF_ELEMENT_BITS;
    localparam int DATA_W       = ((ELEM_BITS + 7) / 8) * 8;
    localparam int IDLE_PCT     = 7;
    localparam int QUIET_START  = 3000;
    localparam int QUIET_END    = 9000;
    localparam int DRAIN_CYCLES = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 480;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              wait_empty;
    } t_element;

    typedef struct {
        logic [PRODUCT_BITS-1:0] product;
        logic                    last;
    } t_others;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    // element_value
    logic [DATA_W-1:0]       i_s_axis_tdata = '0;
    logic                    i_s_axis_tlast = 1'b0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    // product_of_others
    logic [PRODUCT_BITS-1:0] o_m_axis_tdata;
    logic                    o_m_axis_tlast;

    t_element element_q[$];
    t_others  others_q[$];

    // predictor state
    logic [PRODUCT_BITS-1:0] elem_mem   [MAX_EL];
    logic [PRODUCT_BITS-1:0] prefix_mem [MAX_EL];
    logic [PRODUCT_BITS-1:0] run_prod = 64'd1;
    int                      set_count = 0;

    int   error_count = 0;
    int   cycle_count = 0;
    logic in_taken = 1'b0;
    logic quiet;

    assign quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

    product_except_self_unit #(
        .MAX_ELEMENTS (MAX_EL),
        .ELEMENT_BITS (ELEM_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [PRODUCT_BITS-1:0] got,
                                   input logic [PRODUCT_BITS-1:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // store one element; at the end of a set, queue prefix times suffix per element
    task automatic accept_element(input logic [DATA_W-1:0] value, input logic mark);
        logic [PRODUCT_BITS-1:0] suffix;
        logic [PRODUCT_BITS-1:0] suffix_mem [MAX_EL];
        t_others                 res;
        int                      n;
        elem_mem[set_count]   = PRODUCT_BITS'(value[ELEM_BITS-1:0]);
        prefix_mem[set_count] = run_prod;
        run_prod = run_prod * elem_mem[set_count];
        set_count++;
        n = set_count;
        if (mark || n == MAX_EL) begin
            suffix = 64'd1;
            for (int k = n - 1; k >= 0; k--) begin
                suffix_mem[k] = suffix;
                suffix = suffix * elem_mem[k];
            end
            for (int k = 0; k < n; k++) begin
                res.product = prefix_mem[k] * suffix_mem[k];
                res.last    = (k == n - 1);
                others_q.push_back(res);
            end
            set_count = 0;
            run_prod  = 64'd1;
        end
    endtask

    function automatic logic [DATA_W-1:0] rand_element();
        int pick;
        pick = $urandom_range(7);
        case (pick)
            0: rand_element = '0;
            1: rand_element = '1;
            2: rand_element = DATA_W'($urandom_range(3, 1));
            default: rand_element = DATA_W'($urandom_range(255));
        endcase
    endfunction

    task automatic push_element(input logic [DATA_W-1:0] value, input logic last,
                                input logic wait_empty);
        t_element e;
        e.value      = value;
        e.last       = last;
        e.wait_empty = wait_empty;
        element_q.push_back(e);
    endtask

    task automatic add_random_set(input int len, input logic end_marked, input logic hold);
        for (int i = 0; i < len; i++) begin
            push_element(rand_element(), (i == len - 1) ? end_marked : 1'b0,
                         (i == 0) ? hold : 1'b0);
        end
    endtask

    // monitor: checks results, feeds the predictor on accepted words
    always @(posedge i_clk) begin
        t_others want;
        cycle_count <= cycle_count + 1;
        in_taken    <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (others_q.size() == 0) begin
                    report_mismatch("unexpected word", o_m_axis_tdata, '0);
                end else begin
                    want = others_q.pop_front();
                    if (o_m_axis_tdata !== want.product)
                        report_mismatch("product", o_m_axis_tdata, want.product);
                    if (o_m_axis_tlast !== want.last)
                        report_mismatch("tlast", PRODUCT_BITS'(o_m_axis_tlast),
                                        PRODUCT_BITS'(want.last));
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                accept_element(i_s_axis_tdata, i_s_axis_tlast);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // driver: input stream and output back-pressure
    always @(negedge i_clk) begin
        logic              nxt_valid;
        logic [DATA_W-1:0] nxt_data;
        logic              nxt_last;
        nxt_valid = i_s_axis_tvalid && !in_taken;
        nxt_data  = i_s_axis_tdata;
        nxt_last  = i_s_axis_tlast;
        if (i_rst_n && !nxt_valid && element_q.size() > 0
                && !(element_q[0].wait_empty && others_q.size() > 0)
                && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
            nxt_valid = 1'b1;
            nxt_data  = element_q[0].value;
            nxt_last  = element_q[0].last;
            void'(element_q.pop_front());
        end
        i_s_axis_tvalid <= nxt_valid;
        i_s_axis_tdata  <= nxt_data;
        i_s_axis_tlast  <= nxt_last;
        i_m_axis_tready <= i_rst_n && (quiet || $urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        int queued;
        int len;

        // directed sets
        push_element(8'd0, 1'b1, 1'b0);
        push_element(8'd255, 1'b1, 1'b0);
        push_element(8'd255, 1'b0, 1'b0);
        push_element(8'd255, 1'b1, 1'b0);
        push_element(8'd0, 1'b0, 1'b0);
        push_element(8'd0, 1'b0, 1'b0);
        push_element(8'd0, 1'b1, 1'b0);
        push_element(8'd5, 1'b0, 1'b0);
        push_element(8'd0, 1'b0, 1'b0);
        push_element(8'd7, 1'b1, 1'b0);
        for (int i = 1; i <= 4; i++)
            push_element(DATA_W'(i), i == 4, 1'b0);
        for (int i = 0; i < 8; i++)
            push_element(8'd255, i == 7, 1'b0);
        push_element(8'd128, 1'b0, 1'b0);
        push_element(8'd1, 1'b1, 1'b0);

        // full store ends the set by itself, then a full set that is also marked
        add_random_set(MAX_EL, 1'b0, 1'b1);
        add_random_set(MAX_EL, 1'b1, 1'b0);
        queued = 2 * MAX_EL;
        while (queued < RANDOM_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(MAX_EL, 13) : $urandom_range(12, 1);
            add_random_set(len, !(len == MAX_EL && $urandom_range(1) == 0),
                           $urandom_range(14) == 0);
            queued += len;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (element_q.size() > 0 || i_s_axis_tvalid || others_q.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (others_q.size() > 0)
            report_mismatch("results never arrived", PRODUCT_BITS'(others_q.size()), '0);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
